@@ rtl/dwpid_pkg.sv @@
// shared types and constants of the dual wheel pid speed control unit
`default_nettype none

package dwpid_pkg;

  // field and register widths
  localparam int KIND_W    = 2;
  localparam int TGT_W     = 11;
  localparam int REFL_W    = 10;
  localparam int GAIN_W    = 16;
  localparam int THR_W     = 10;
  localparam int EFF_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  // datapath widths
  localparam int ERR_W     = 24;  // saturated error, q.8
  localparam int DIFF_W    = 25;  // error difference for the derivative
  localparam int CORR_W    = 28;  // line correction product
  localparam int ERRSUM_W  = 29;  // error before saturation
  localparam int MUL_A_W   = 17;  // gain operand, zero extended
  localparam int MUL_B_W   = 26;  // signed value operand
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 61;  // term accumulator
  localparam int SPLIT     = 22;  // low chunk of the clamped integral
  localparam int ICLAMP_W  = 44;  // integral clamped to the term limit
  localparam int TERM_SHIFT = 42; // integral term limit is 2**42
  localparam int FRAC_W    = 16;  // fraction bits of the q.16 sum
  localparam int EFFORT_LIMIT = 300;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SPEED,
    KIND_LINE,
    KIND_CLR_INT,
    KIND_CLR_ALL
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEGRAL_GAIN,
    REG_DERIV_GAIN,
    REG_LINE_GAIN,
    REG_LINE_THRESHOLD
  } cfg_reg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_CLEAR,
    ST_ERR,
    ST_INT_HI,
    ST_INT_LO,
    ST_ISUM,
    ST_TCLAMP,
    ST_PROP,
    ST_DERIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LINE,
    OP_ERR,
    OP_CLEAR,
    OP_INT_HI,
    OP_INT_LO,
    OP_ISUM,
    OP_TCLAMP,
    OP_PROP,
    OP_DERIV,
    OP_FIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ch;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/dual_wheel_pid_speed_control_unit.sv @@
// top level of the dual wheel pid speed control unit
//
//   channel  direction  handshake          payload
//   s_       in         s_tvalid/s_tready  s_tuser kind, s_tdata targets, speeds, reflectance
//   m_       out        m_tvalid/m_tready  m_tdata left and right effort
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// speed and line-follow requests run seven steps per wheel on one shared 17x26
// multiplier with a registered product; a new request is accepted only in the
// idle state. clear requests skip the wheel steps.
// rst is synchronous; gains and controller state return to their defaults.
// the result register lets the next request run while a result is stalled;
// a finished request waits only if the previous result is still not taken.
`default_nettype none

module dual_wheel_pid_speed_control_unit import dwpid_pkg::*; #(
  parameter int INTEGRAL_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [GAIN_W-1:0]      cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // target_left, target_right, measured_left, measured_right, reflect_left, reflect_right
  input  wire logic [IN_DATA_W-1:0]   s_tdata,
  // kind
  input  wire logic [KIND_W-1:0]      s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // effort_left, effort_right, zero padding
  output logic [OUT_DATA_W-1:0]       m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  dwpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  dwpid_dp #(
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_kind   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/dwpid_ctrl.sv @@
// sequencer that steps the datapath through one request
`default_nettype none

module dwpid_ctrl import dwpid_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state, state_next;
  logic   ch, ch_next;

  // state and channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    ch_next    = ch;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LINE;
      ST_LINE: begin
        if (status.kind inside {KIND_CLR_INT, KIND_CLR_ALL}) state_next = ST_CLEAR;
        else state_next = ST_ERR;
      end
      ST_CLEAR:  state_next = ST_OUT;
      ST_ERR: begin
        state_next = ST_INT_HI;
        ch_next    = 1'b0;
      end
      ST_INT_HI: state_next = ST_INT_LO;
      ST_INT_LO: state_next = ST_ISUM;
      ST_ISUM:   state_next = ST_TCLAMP;
      ST_TCLAMP: state_next = ST_PROP;
      ST_PROP:   state_next = ST_DERIV;
      ST_DERIV:  state_next = ST_FIN;
      ST_FIN: begin
        ch_next    = ~ch;
        state_next = ch ? ST_OUT : ST_INT_HI;
      end
      ST_OUT:    if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.ch   = ch;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_LINE:   cmd.op = OP_LINE;
      ST_CLEAR:  cmd.op = OP_CLEAR;
      ST_ERR:    cmd.op = OP_ERR;
      ST_INT_HI: cmd.op = OP_INT_HI;
      ST_INT_LO: cmd.op = OP_INT_LO;
      ST_ISUM:   cmd.op = OP_ISUM;
      ST_TCLAMP: cmd.op = OP_TCLAMP;
      ST_PROP:   cmd.op = OP_PROP;
      ST_DERIV:  cmd.op = OP_DERIV;
      ST_FIN:    cmd.op = OP_FIN;
      ST_OUT:    if (status.out_free) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dwpid_dp.sv @@
// datapath: gains, controller state, shared multiplier, accumulator, result register
`default_nettype none

module dwpid_dp import dwpid_pkg::*; #(
  parameter int INTEGRAL_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [GAIN_W-1:0]     cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int ISUM_W = ((INTEGRAL_BITS > ERR_W) ? INTEGRAL_BITS : ERR_W) + 1;
  localparam int IEXT_W = (INTEGRAL_BITS > ICLAMP_W) ? INTEGRAL_BITS : ICLAMP_W;
  localparam logic signed [ISUM_W-1:0] IMAX = ISUM_W'((64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1);
  localparam logic signed [ISUM_W-1:0] IMIN = -IMAX - ISUM_W'(1);
  localparam logic signed [IEXT_W-1:0] TLIM_E = IEXT_W'(64'sd1 <<< TERM_SHIFT);
  localparam logic signed [ACC_W-1:0]  TLIM_A = ACC_W'(64'sd1 <<< TERM_SHIFT);
  localparam logic signed [ACC_W-1:0]  ELIM_A = ACC_W'(EFFORT_LIMIT);

  // saturate an error to 24 bits
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERRSUM_W-1:0] v);
    logic signed [ERRSUM_W-1:0] hi;
    logic signed [ERRSUM_W-1:0] lo;
    hi = ERRSUM_W'(24'sh7fffff);
    lo = -hi - ERRSUM_W'(1);
    if (v > hi) return ERR_W'(hi);
    else if (v < lo) return ERR_W'(lo);
    else return ERR_W'(v);
  endfunction

  // configuration registers
  logic [GAIN_W-1:0] prop_gain, integral_gain, deriv_gain, line_gain;
  logic [THR_W-1:0]  line_threshold;

  // latched request
  kind_t                     kind_q;
  logic signed [TGT_W-1:0]   tl, tr, ml, mr;
  logic        [REFL_W-1:0]  rl, rr;

  // controller state and working registers
  logic signed [INTEGRAL_BITS-1:0] integ [2];
  logic signed [ERR_W-1:0]         last_err [2];
  logic signed [ERR_W-1:0]         err_w [2];
  logic signed [DIFF_W-1:0]        d_w [2];
  logic signed [EFF_W-1:0]         eff [2];
  logic signed [MUL_P_W-1:0]       prod;
  logic signed [ACC_W-1:0]         acc;

  // combinational values
  logic                            line_on;
  logic signed [REFL_W:0]          rdiff;
  logic signed [CORR_W-1:0]        corr;
  logic signed [TGT_W:0]           dl, dr;
  logic signed [ERRSUM_W-1:0]      el_sum, er_sum;
  logic signed [ERR_W-1:0]         err_sat [2];
  logic signed [DIFF_W-1:0]        d_new [2];
  logic signed [ISUM_W-1:0]        isum [2];
  logic signed [INTEGRAL_BITS-1:0] i_new [2];
  logic signed [IEXT_W-1:0]        iext;
  logic signed [ICLAMP_W-1:0]      iclamp;
  logic signed [MUL_A_W-1:0]       mul_a;
  logic signed [MUL_B_W-1:0]       mul_b;
  logic signed [MUL_P_W-1:0]       mul_p;
  logic signed [ACC_W-1:0]         acc_clamp;
  logic signed [ACC_W-1:0]         quo;
  logic signed [EFF_W-1:0]         eff_new;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= GAIN_W'(256);
      integral_gain  <= '0;
      deriv_gain     <= '0;
      line_gain      <= GAIN_W'(26);
      line_threshold <= THR_W'(300);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:      prop_gain      <= cfg_data;
        REG_INTEGRAL_GAIN:  integral_gain  <= cfg_data;
        REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
        REG_LINE_GAIN:      line_gain      <= cfg_data;
        REG_LINE_THRESHOLD: line_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      kind_q <= kind_t'(in_kind);
      tl <= in_data[10:0];
      tr <= in_data[21:11];
      ml <= in_data[32:22];
      mr <= in_data[43:33];
      rl <= in_data[53:44];
      rr <= in_data[63:54];
    end
  end

  // errors, derivatives and integral updates for both wheels
  always_comb begin
    line_on = (kind_q == KIND_LINE) && ((rl >= line_threshold) || (rr >= line_threshold));
    rdiff   = $signed({1'b0, rl}) - $signed({1'b0, rr});
    corr    = prod[CORR_W-1:0];
    dl      = (TGT_W+1)'(tl) - (TGT_W+1)'(ml);
    dr      = (kind_q == KIND_LINE) ? (TGT_W+1)'(tl) - (TGT_W+1)'(mr)
                                    : (TGT_W+1)'(tr) - (TGT_W+1)'(mr);
    el_sum  = (ERRSUM_W'(dl) <<< 8) + ERRSUM_W'(corr);
    er_sum  = (ERRSUM_W'(dr) <<< 8) - ERRSUM_W'(corr);
    err_sat[0] = sat_err(el_sum);
    err_sat[1] = sat_err(er_sum);
    for (int i = 0; i < 2; i++) begin
      d_new[i] = DIFF_W'(err_sat[i]) - DIFF_W'(last_err[i]);
      isum[i]  = ISUM_W'(integ[i]) + ISUM_W'(err_sat[i]);
      if (isum[i] > IMAX) i_new[i] = INTEGRAL_BITS'(IMAX);
      else if (isum[i] < IMIN) i_new[i] = INTEGRAL_BITS'(IMIN);
      else i_new[i] = INTEGRAL_BITS'(isum[i]);
    end
  end

  // integral clamped to the term limit, split into two multiplier chunks
  always_comb begin
    iext = IEXT_W'(integ[cmd.ch]);
    if (iext > TLIM_E) iclamp = ICLAMP_W'(TLIM_E);
    else if (iext < -TLIM_E) iclamp = ICLAMP_W'(-TLIM_E);
    else iclamp = ICLAMP_W'(iext);
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LINE: begin
        mul_a = line_on ? $signed({1'b0, line_gain}) : '0;
        mul_b = MUL_B_W'(rdiff);
      end
      OP_INT_HI: begin
        mul_a = $signed({1'b0, integral_gain});
        mul_b = MUL_B_W'($signed(iclamp[ICLAMP_W-1:SPLIT]));
      end
      OP_INT_LO: begin
        mul_a = $signed({1'b0, integral_gain});
        mul_b = MUL_B_W'($signed({1'b0, iclamp[SPLIT-1:0]}));
      end
      OP_TCLAMP: begin
        mul_a = $signed({1'b0, prop_gain});
        mul_b = MUL_B_W'(err_w[cmd.ch]);
      end
      OP_PROP: begin
        mul_a = $signed({1'b0, deriv_gain});
        mul_b = MUL_B_W'(d_w[cmd.ch]);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // term limit and rounding toward zero with effort saturation
  always_comb begin
    if (acc > TLIM_A) acc_clamp = TLIM_A;
    else if (acc < -TLIM_A) acc_clamp = -TLIM_A;
    else acc_clamp = acc;
    quo = (acc >>> FRAC_W)
        + ACC_W'((acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0)) ? 1 : 0);
    if (quo > ELIM_A) eff_new = EFF_W'(ELIM_A);
    else if (quo < -ELIM_A) eff_new = EFF_W'(-ELIM_A);
    else eff_new = EFF_W'(quo);
  end

  // product register and accumulator
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (cmd.op)
      OP_INT_LO: acc <= ACC_W'(prod) <<< SPLIT;
      OP_ISUM, OP_PROP, OP_DERIV: acc <= acc + ACC_W'(prod);
      OP_TCLAMP: acc <= acc_clamp;
      default: ;
    endcase
  end

  // working registers and efforts
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ERR) begin
      for (int i = 0; i < 2; i++) begin
        err_w[i] <= err_sat[i];
        d_w[i]   <= d_new[i];
      end
    end
    if (cmd.op == OP_FIN) eff[cmd.ch] <= eff_new;
    if (cmd.op == OP_CLEAR) begin
      eff[0] <= '0;
      eff[1] <= '0;
    end
  end

  // integrals and last errors
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        integ[i]    <= '0;
        last_err[i] <= '0;
      end
    end else if (cmd.op == OP_ERR) begin
      for (int i = 0; i < 2; i++) begin
        integ[i]    <= i_new[i];
        last_err[i] <= err_sat[i];
      end
    end else if (cmd.op == OP_CLEAR) begin
      for (int i = 0; i < 2; i++) begin
        integ[i] <= '0;
        if (kind_q == KIND_CLR_ALL) last_err[i] <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) out_data <= {4'b0, eff[1], eff[0]};
  end

  assign status.kind     = kind_q;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire
